FILE: rtl/jcsd_pkg.sv
// ----------------------------------------------------------------------------
// jcsd_pkg
// shared constants for the joystick center, scale and deadzone unit
// ----------------------------------------------------------------------------
package jcsd_pkg;

   localparam int ADC_BITS_DEF = 12;
   localparam int Q_BITS       = 15;
   localparam int STICK_W      = 16;
   localparam int DZ_W         = 15;
   localparam int CSR_IDX_W    = 3;

   // register stages inside one axis: operand, numerator, quotient bits, result
   localparam int AXIS_LATENCY = Q_BITS + 3;

   localparam logic [STICK_W-1:0] STICK_POS_SAT = {1'b0, {(STICK_W-1){1'b1}}};
   localparam logic [STICK_W-1:0] STICK_NEG_SAT = {1'b1, {(STICK_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERT_X = 3'd0,
      CSR_INVERT_Y = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_DEADZONE = 3'd4
   } csr_index_type;

endpackage

FILE: rtl/jcsd_axis.sv
// ----------------------------------------------------------------------------
// jcsd_axis
// one axis: mirror, center offset and pipelined restoring divide with clamp
// ----------------------------------------------------------------------------
module jcsd_axis import jcsd_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [ADC_BITS-1:0]        raw,
   input  logic                       invert,
   input  logic [ADC_BITS-1:0]        center,
   output logic                       out_valid,
   output logic signed [STICK_W-1:0]  out_value
);

   localparam int AW = ADC_BITS;
   localparam int QW = Q_BITS;
   localparam int NW = ADC_BITS + Q_BITS;
   localparam logic [AW-1:0] ADC_MAX = {AW{1'b1}};

   // operand stage
   logic [AW-1:0] s_in;
   logic          pos_in;
   logic          neg_in;
   logic [AW-1:0] mag_in;
   logic [AW-1:0] den_in;

   logic          a_valid_ff;
   logic          a_neg_ff;
   logic          a_zero_ff;
   logic [AW-1:0] a_mag_ff;
   logic [AW-1:0] a_den_ff;

   always_comb begin
      s_in   = invert ? (ADC_MAX - raw) : raw;
      pos_in = s_in > center;
      neg_in = s_in < center;
      mag_in = pos_in ? (s_in - center) : (center - s_in);
      den_in = pos_in ? (ADC_MAX - center) : center;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_neg_ff  <= neg_in;
      a_zero_ff <= (!pos_in && !neg_in) || (den_in == '0);
      a_mag_ff  <= mag_in;
      a_den_ff  <= den_in;
   end

   // numerator stage
   logic [NW-1:0] num_in;
   logic [NW-1:0] den_top_in;

   logic          d_valid_ff [0:QW];
   logic [QW-1:0] d_q_ff     [0:QW];
   logic          d_neg_ff   [0:QW];
   logic          d_zero_ff  [0:QW];
   logic          d_sat_ff   [0:QW];
   logic [NW-1:0] d_rem_ff   [0:QW-1];
   logic [AW-1:0] d_den_ff   [0:QW-1];

   always_comb begin
      num_in     = {a_mag_ff, {QW{1'b0}}} - (a_neg_ff ? '0 : NW'(a_mag_ff));
      den_top_in = {a_den_ff, {QW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else begin
         d_valid_ff[0] <= a_valid_ff;
      end
      d_q_ff[0]    <= '0;
      d_neg_ff[0]  <= a_neg_ff;
      d_zero_ff[0] <= a_zero_ff;
      d_sat_ff[0]  <= num_in >= den_top_in;
      d_rem_ff[0]  <= num_in;
      d_den_ff[0]  <= a_den_ff;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int SH = QW - 1 - k;
      logic [NW-1:0] trial;
      logic          take;

      assign trial = NW'(d_den_ff[k]) << SH;
      assign take  = d_rem_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[k+1] <= 1'b0;
         end else begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
         d_q_ff[k+1]    <= {d_q_ff[k][QW-2:0], take};
         d_neg_ff[k+1]  <= d_neg_ff[k];
         d_zero_ff[k+1] <= d_zero_ff[k];
         d_sat_ff[k+1]  <= d_sat_ff[k];
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            d_rem_ff[k+1] <= take ? (d_rem_ff[k] - trial) : d_rem_ff[k];
            d_den_ff[k+1] <= d_den_ff[k];
         end
      end
   end

   // sign and clamp
   logic [STICK_W-1:0] mag_q;
   logic [STICK_W-1:0] value_in;
   logic               v_valid_ff;
   logic [STICK_W-1:0] v_value_ff;

   always_comb begin
      mag_q = {1'b0, d_q_ff[QW]};
      priority if (d_zero_ff[QW]) begin
         value_in = '0;
      end else if (d_sat_ff[QW]) begin
         value_in = d_neg_ff[QW] ? STICK_NEG_SAT : STICK_POS_SAT;
      end else begin
         value_in = d_neg_ff[QW] ? (~mag_q + 1'b1) : mag_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else begin
         v_valid_ff <= d_valid_ff[QW];
      end
      v_value_ff <= value_in;
   end

   assign out_valid = v_valid_ff;
   assign out_value = $signed(v_value_ff);

endmodule

FILE: rtl/joystick_center_scale_deadzone_unit.sv
// ----------------------------------------------------------------------------
// joystick_center_scale_deadzone_unit
// centered, scaled stick values from adc sample pairs with a radial deadzone
// ----------------------------------------------------------------------------
// A sample pair is taken on every clock where start is high and busy is low;
// busy is high only during reset, so one beat per cycle is sustained. Each
// result appears on rsp_stick_x/rsp_stick_y with rsp_strobe for one cycle,
// exactly 20 cycles (Q_BITS + 5) after its sample was taken, in order, and
// must be captured then. The latency is set by the divider in each axis,
// which resolves one quotient bit per pipeline stage. Write the registers
// only while no beat is in flight.
module joystick_center_scale_deadzone_unit import jcsd_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   output logic                                            busy,
   input  logic [ADC_BITS-1:0]                             req_raw_x,
   input  logic [ADC_BITS-1:0]                             req_raw_y,
   output logic                                            rsp_strobe,
   output logic signed [STICK_W-1:0]                       rsp_stick_x,
   output logic signed [STICK_W-1:0]                       rsp_stick_y,
   input  logic                                            csr_we,
   input  logic [CSR_IDX_W-1:0]                            csr_index,
   input  logic [((ADC_BITS > DZ_W) ? ADC_BITS : DZ_W)-1:0] csr_wdata
);

   localparam int SQ_W = 2 * STICK_W - 1;
   localparam int LAT  = AXIS_LATENCY + 2;
   localparam logic [ADC_BITS-1:0] CENTER_RST = {1'b1, {(ADC_BITS-1){1'b0}}};

   // configuration registers
   logic                invert_x_ff;
   logic                invert_y_ff;
   logic [ADC_BITS-1:0] center_x_ff;
   logic [ADC_BITS-1:0] center_y_ff;
   logic [DZ_W-1:0]     deadzone_ff;
   logic [2*DZ_W-1:0]   dz_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_x_ff <= 1'b0;
         invert_y_ff <= 1'b0;
         center_x_ff <= CENTER_RST;
         center_y_ff <= CENTER_RST;
         deadzone_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INVERT_X: invert_x_ff <= csr_wdata[0];
            CSR_INVERT_Y: invert_y_ff <= csr_wdata[0];
            CSR_CENTER_X: center_x_ff <= csr_wdata[ADC_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[ADC_BITS-1:0];
            CSR_DEADZONE: deadzone_ff <= csr_wdata[DZ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      dz_sq_ff <= deadzone_ff * deadzone_ff;
   end

   assign busy = reset;

   logic                      accept;
   logic                      ax_valid_x;
   logic                      ax_valid_y;
   logic signed [STICK_W-1:0] ax_x;
   logic signed [STICK_W-1:0] ax_y;

   assign accept = start && !busy;

   jcsd_axis #(.ADC_BITS(ADC_BITS)) u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .raw       (req_raw_x),
      .invert    (invert_x_ff),
      .center    (center_x_ff),
      .out_valid (ax_valid_x),
      .out_value (ax_x)
   );

   jcsd_axis #(.ADC_BITS(ADC_BITS)) u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .raw       (req_raw_y),
      .invert    (invert_y_ff),
      .center    (center_y_ff),
      .out_valid (ax_valid_y),
      .out_value (ax_y)
   );

   // squares
   logic signed [2*STICK_W-1:0] xx_in;
   logic signed [2*STICK_W-1:0] yy_in;
   logic                        sq_valid_ff;
   logic signed [STICK_W-1:0]   sq_x_ff;
   logic signed [STICK_W-1:0]   sq_y_ff;
   logic [SQ_W-1:0]             sq_xx_ff;
   logic [SQ_W-1:0]             sq_yy_ff;

   assign xx_in = ax_x * ax_x;
   assign yy_in = ax_y * ax_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= ax_valid_x;
      end
      sq_x_ff  <= ax_x;
      sq_y_ff  <= ax_y;
      sq_xx_ff <= xx_in[SQ_W-1:0];
      sq_yy_ff <= yy_in[SQ_W-1:0];
   end

   // deadzone and output beat
   logic [SQ_W:0] rad_in;
   logic          inside_in;
   logic          rsp_strobe_ff;
   logic signed [STICK_W-1:0] rsp_x_ff;
   logic signed [STICK_W-1:0] rsp_y_ff;

   assign rad_in    = {1'b0, sq_xx_ff} + {1'b0, sq_yy_ff};
   assign inside_in = rad_in <= (SQ_W+1)'(dz_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sq_valid_ff;
      end
      rsp_x_ff <= inside_in ? '0 : sq_x_ff;
      rsp_y_ff <= inside_in ? '0 : sq_y_ff;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_stick_x = rsp_x_ff;
   assign rsp_stick_y = rsp_y_ff;

`ifndef SYNTHESIS
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      ax_valid_x == ax_valid_y)
      else $error("axis pipelines out of step");

   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result beat without a matching sample beat");

   a_accept_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("sample beat lost in pipeline");
`endif

endmodule

FILE: tb/joystick_center_scale_deadzone_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_center_scale_deadzone_unit_tb
// drives adc sample pairs into the unit under several register settings and
// compares every stick result, field by field, against a predictor kept in
// step with the register writes; results are matched in order of acceptance
// ----------------------------------------------------------------------------
module joystick_center_scale_deadzone_unit_tb;
   import jcsd_pkg::*;

   localparam int          ADC_W       = ADC_BITS_DEF;
   localparam int          WDATA_W     = (ADC_W > DZ_W) ? ADC_W : DZ_W;
   localparam longint      ADC_FULL    = (64'd1 << ADC_W) - 1;
   localparam int          DRAIN       = AXIS_LATENCY + 8;
   localparam int          CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [STICK_W-1:0] sx;
      logic signed [STICK_W-1:0] sy;
   } stick_pair_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [ADC_W-1:0]          req_raw_x;
   logic [ADC_W-1:0]          req_raw_y;
   logic                      rsp_strobe;
   logic signed [STICK_W-1:0] rsp_stick_x;
   logic signed [STICK_W-1:0] rsp_stick_y;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [WDATA_W-1:0]        csr_wdata;

   // predictor copy of the registers
   logic                      cfg_invert_x;
   logic                      cfg_invert_y;
   logic [ADC_W-1:0]          cfg_center_x;
   logic [ADC_W-1:0]          cfg_center_y;
   logic [DZ_W-1:0]           cfg_deadzone;

   stick_pair_type            pending_sticks[$];
   stick_pair_type            oldest;
   int                        mismatch_count = 0;
   int                        cycle_count    = 0;
   bit                        gaps_on        = 1'b1;
   bit                        pipe_dirty     = 1'b0;

   joystick_center_scale_deadzone_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_raw_x   (req_raw_x),
      .req_raw_y   (req_raw_y),
      .rsp_strobe  (rsp_strobe),
      .rsp_stick_x (rsp_stick_x),
      .rsp_stick_y (rsp_stick_y),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic signed [STICK_W-1:0] axis_value(input logic [ADC_W-1:0] raw,
                                                           input logic inv,
                                                           input logic [ADC_W-1:0] ctr);
      longint s;
      longint c;
      longint d;
      longint v;
      longint span;
      s = raw;
      c = ctr;
      if (inv) s = ADC_FULL - s;
      d = s - c;
      if (d == 0) return '0;
      if (d > 0) begin
         span = ADC_FULL - c;
         if (span <= 0) return '0;
         v = d * 32767 / span;
         if (v > 32767) v = 32767;
      end else begin
         span = c;
         if (span <= 0) return '0;
         v = d * 32768 / span;
         if (v < -32768) v = -32768;
      end
      return v[STICK_W-1:0];
   endfunction

   function automatic stick_pair_type condition_pair(input logic [ADC_W-1:0] x,
                                                     input logic [ADC_W-1:0] y);
      stick_pair_type p;
      longint         lx;
      longint         ly;
      longint         dz;
      p.sx = axis_value(x, cfg_invert_x, cfg_center_x);
      p.sy = axis_value(y, cfg_invert_y, cfg_center_y);
      lx   = p.sx;
      ly   = p.sy;
      dz   = cfg_deadzone;
      // full-width squares, no wrap at the corners
      if (lx * lx + ly * ly <= dz * dz) begin
         p.sx = '0;
         p.sy = '0;
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d, %s: got %0d expected %0d", cycle_count, what, got,
               want);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_sticks.size() == 0) begin
            report_mismatch("result with nothing pending, stick_x", rsp_stick_x, 0);
         end else begin
            oldest = pending_sticks.pop_front();
            if (rsp_stick_x !== oldest.sx) report_mismatch("stick_x", rsp_stick_x, oldest.sx);
            if (rsp_stick_y !== oldest.sy) report_mismatch("stick_y", rsp_stick_y, oldest.sy);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("joystick_center_scale_deadzone_unit_tb NOT OK");
         $finish;
      end
   end

   // one sample pair beat; entered and left at a falling edge
   task automatic send_pair(input logic [ADC_W-1:0] x, input logic [ADC_W-1:0] y);
      if (gaps_on && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start     <= 1'b1;
      req_raw_x <= x;
      req_raw_y <= y;
      do @(posedge clock); while (busy);
      pending_sticks.push_back(condition_pair(x, y));
      pipe_dirty = 1'b1;
      @(negedge clock);
   endtask

   // register write while idle; the predictor copy follows
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WDATA_W-1:0] data);
      start <= 1'b0;
      if (pipe_dirty) begin
         while (pending_sticks.size() != 0) @(negedge clock);
         repeat (DRAIN) @(negedge clock);
         pipe_dirty = 1'b0;
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      unique case (idx)
         CSR_INVERT_X: cfg_invert_x = data[0];
         CSR_INVERT_Y: cfg_invert_y = data[0];
         CSR_CENTER_X: cfg_center_x = data[ADC_W-1:0];
         CSR_CENTER_Y: cfg_center_y = data[ADC_W-1:0];
         CSR_DEADZONE: cfg_deadzone = data[DZ_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // all five registers, junk above each register's width
   task automatic set_regs(input logic ix, input logic iy, input logic [ADC_W-1:0] cx,
                           input logic [ADC_W-1:0] cy, input logic [DZ_W-1:0] dz);
      logic [WDATA_W-1:0] junk;
      junk = WDATA_W'($urandom);
      write_reg(CSR_INVERT_X, {junk[WDATA_W-1:1], ix});
      junk = WDATA_W'($urandom);
      write_reg(CSR_INVERT_Y, {junk[WDATA_W-1:1], iy});
      junk = WDATA_W'($urandom);
      write_reg(CSR_CENTER_X, {junk[WDATA_W-1:ADC_W], cx});
      junk = WDATA_W'($urandom);
      write_reg(CSR_CENTER_Y, {junk[WDATA_W-1:ADC_W], cy});
      write_reg(CSR_DEADZONE, dz);
   endtask

   task automatic write_unused_regs();
      for (int i = CSR_DEADZONE + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(i[CSR_IDX_W-1:0], WDATA_W'($urandom));
   endtask

   function automatic logic [ADC_W-1:0] pick_center();
      unique case ($urandom_range(7))
         0: return '0;
         1: return ADC_FULL[ADC_W-1:0];
         2: return ADC_W'($urandom_range(1, 15));
         3: return ADC_FULL[ADC_W-1:0] - ADC_W'($urandom_range(1, 15));
         default: return ADC_W'($urandom);
      endcase
   endfunction

   function automatic logic [DZ_W-1:0] pick_deadzone();
      unique case ($urandom_range(5))
         0: return '0;
         1: return {DZ_W{1'b1}};
         2: return DZ_W'($urandom_range(0, 2000));
         3: return DZ_W'($urandom_range(20000, 32767));
         default: return DZ_W'($urandom);
      endcase
   endfunction

   // raw sample: full range, rails, or near the rest position
   function automatic logic [ADC_W-1:0] pick_raw(input logic inv, input logic [ADC_W-1:0] ctr);
      longint s;
      unique case ($urandom_range(9))
         0: return $urandom_range(1) ? ADC_FULL[ADC_W-1:0] : '0;
         1, 2, 3: begin
            s = longint'(ctr) + $urandom_range(0, 128) - 64;
            if (s < 0) s = 0;
            if (s > ADC_FULL) s = ADC_FULL;
            if (inv) s = ADC_FULL - s;
            return s[ADC_W-1:0];
         end
         default: return ADC_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_values();
      send_pair(12'd2048, 12'd2048);
      send_pair(12'd0, 12'd0);
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd0);
      send_pair(12'd2049, 12'd2047);
   endtask

   task automatic test_corner_settings();
      // mirrored axes, zero center on x and full-scale center on y
      set_regs(1'b1, 1'b1, 12'd0, 12'd4095, 15'd0);
      send_pair(12'd0, 12'd0);
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd2048, 12'd100);
      // full-scale centers, widest deadzone: corners survive the squares
      set_regs(1'b0, 1'b0, 12'd4095, 12'd4095, 15'h7fff);
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd0, 12'd0);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd1, 12'd4095);
      // zero centers, moderate deadzone, mirrored x
      set_regs(1'b1, 1'b0, 12'd0, 12'd0, 15'd1000);
      send_pair(12'd4095, 12'd0);
      send_pair(12'd0, 12'd0);
      send_pair(12'd0, 12'd10);
      send_pair(12'd4095, 12'd10);
   endtask

   task automatic test_unused_index();
      set_regs(1'b0, 1'b1, 12'd1000, 12'd3000, 15'd500);
      write_unused_regs();
      send_pair(12'd1000, 12'd1095);
      send_pair(12'd4095, 12'd0);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 10; phase++) begin
         set_regs(1'($urandom_range(1)), 1'($urandom_range(1)), pick_center(), pick_center(),
                  pick_deadzone());
         if ($urandom_range(3) == 0) write_unused_regs();
         gaps_on = (phase != 3);
         for (int n = 0; n < 123; n++)
            send_pair(pick_raw(cfg_invert_x, cfg_center_x), pick_raw(cfg_invert_y, cfg_center_y));
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_raw_x = '0;
      req_raw_y = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_invert_x = 1'b0;
      cfg_invert_y = 1'b0;
      cfg_center_x = 12'd2048;
      cfg_center_y = 12'd2048;
      cfg_deadzone = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_corner_settings();
      test_unused_index();
      test_random_settings();

      start <= 1'b0;
      while (pending_sticks.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("joystick_center_scale_deadzone_unit_tb OK");
      end else begin
         $display("joystick_center_scale_deadzone_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/jcsd_pkg.sv
rtl/jcsd_axis.sv
rtl/joystick_center_scale_deadzone_unit.sv
tb/joystick_center_scale_deadzone_unit_tb.sv
